/* sv/ucal_pkg.sv */
package ucal_pkg;

  // field widths of the ports
  localparam int unsigned SECS_W  = 32;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned MDAY_W  = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned WDAY_W  = 3;

  // whole days since epoch (at most 49710) and seconds of the day (below 86400)
  localparam int unsigned DAYS_W = 16;
  localparam int unsigned TOD_W  = 17;

  // split of a word into day count and time of day
  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
  } ucal_day_t;

  // calendar part of a result word
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [MDAY_W-1:0]  mday;
    logic [WDAY_W-1:0]  weekday;
  } ucal_date_t;

  // clock part of a result word
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } ucal_hms_t;

  typedef struct packed {
    ucal_date_t date;
    ucal_hms_t  hms;
  } ucal_result_t;

endpackage

/* sv/ucal_day_split.sv */
module ucal_day_split (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [ucal_pkg::SECS_W-1:0] secs_i,
  output logic                        valid_o,
  output ucal_pkg::ucal_day_t         day_o
);

  // 86400 = 128 * 675; divide the upper 25 bits by 675 with a reciprocal
  localparam logic [9:0]  DIV       = 10'd675;
  localparam logic [15:0] RECIP     = 16'd49710;
  localparam int unsigned RECIP_SH  = 25;

  logic        v1_q, v2_q, v3_q;
  logic [24:0] x_d, x1_q;
  logic [6:0]  lo1_q, lo2_q;
  logic [40:0] prod_d, prod1_q;
  logic [15:0] q0_d, q2_q;
  logic [24:0] r0_full_d;
  logic [10:0] r2_q, r_fix_d;
  logic        carry_d;
  ucal_pkg::ucal_day_t day_d, day_q;

  // stage 1: estimate quotient product
  assign x_d    = secs_i[31:7];
  assign prod_d = 41'(x_d) * 41'(RECIP);

  // stage 2: quotient estimate and its remainder, low by at most one divisor
  assign q0_d      = prod1_q[40:RECIP_SH];
  assign r0_full_d = x1_q - 25'(q0_d) * 25'(DIV);

  // stage 3: single correction step
  always_comb begin
    carry_d  = (r2_q >= 11'(DIV));
    r_fix_d  = carry_d ? (r2_q - 11'(DIV)) : r2_q;
    day_d.days = q2_q + 16'(carry_d);
    day_d.tod  = {r_fix_d[9:0], lo2_q};
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // data path
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= x_d;
      lo1_q   <= secs_i[6:0];
      prod1_q <= prod_d;
      q2_q    <= q0_d;
      r2_q    <= r0_full_d[10:0];
      lo2_q   <= lo1_q;
      day_q   <= day_d;
    end
  end

  assign valid_o = v3_q;
  assign day_o   = day_q;

endmodule

/* sv/ucal_clock.sv */
module ucal_clock (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [ucal_pkg::TOD_W-1:0] tod_i,
  output ucal_pkg::ucal_hms_t        hms_o
);

  // 3600 = 16 * 225, 60 = 4 * 15
  localparam logic [7:0]  HOUR_DIV   = 8'd225;
  localparam logic [12:0] HOUR_RECIP = 13'd4660;
  localparam int unsigned HOUR_SH    = 20;
  localparam logic [3:0]  MIN_DIV    = 4'd15;
  localparam logic [10:0] MIN_RECIP  = 11'd1092;
  localparam int unsigned MIN_SH     = 14;

  logic [12:0] z_d, z4_q;
  logic [25:0] ph_d, ph4_q;
  logic [3:0]  lo4_q, lo5_q;
  logic [5:0]  h0_d;
  logic [12:0] rh_full_d;
  logic [4:0]  h5_q, hour6_q, hour7_q, hour8_q;
  logic [8:0]  rh5_q, rh_fix_d;
  logic        hcarry_d;
  logic [11:0] rem6_q;
  logic [20:0] pm_d, pm7_q;
  logic [9:0]  w7_q;
  logic [1:0]  lo7_q, lo8_q;
  logic [6:0]  m0_d;
  logic [9:0]  r_full_d;
  logic [5:0]  m8_q;
  logic [4:0]  r8_q, r_fix_d;
  logic        mcarry_d;
  ucal_pkg::ucal_hms_t hms_d, hms9_q, hms10_q, hms11_q;

  // stage 4: hour quotient product
  assign z_d  = tod_i[16:4];
  assign ph_d = 26'(z_d) * 26'(HOUR_RECIP);

  // stage 5: hour estimate and remainder
  assign h0_d      = ph4_q[25:HOUR_SH];
  assign rh_full_d = z4_q - 13'(h0_d) * 13'(HOUR_DIV);

  // stage 6: hour correction
  assign hcarry_d = (rh5_q >= 9'(HOUR_DIV));
  assign rh_fix_d = hcarry_d ? (rh5_q - 9'(HOUR_DIV)) : rh5_q;

  // stage 7: minute quotient product on seconds of the hour
  assign pm_d = 21'(rem6_q[11:2]) * 21'(MIN_RECIP);

  // stage 8: minute estimate and remainder
  assign m0_d     = pm7_q[20:MIN_SH];
  assign r_full_d = w7_q - 10'(m0_d) * 10'(MIN_DIV);

  // stage 9: minute correction, seconds from what is left
  always_comb begin
    mcarry_d     = (r8_q >= 5'(MIN_DIV));
    r_fix_d      = mcarry_d ? (r8_q - 5'(MIN_DIV)) : r8_q;
    hms_d.hour   = hour8_q;
    hms_d.minute = m8_q + 6'(mcarry_d);
    hms_d.second = {r_fix_d[3:0], lo8_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z4_q    <= z_d;
      ph4_q   <= ph_d;
      lo4_q   <= tod_i[3:0];
      h5_q    <= h0_d[4:0];
      rh5_q   <= rh_full_d[8:0];
      lo5_q   <= lo4_q;
      hour6_q <= h5_q + 5'(hcarry_d);
      rem6_q  <= {rh_fix_d[7:0], lo5_q};
      pm7_q   <= pm_d;
      w7_q    <= rem6_q[11:2];
      lo7_q   <= rem6_q[1:0];
      hour7_q <= hour6_q;
      m8_q    <= m0_d[5:0];
      r8_q    <= r_full_d[4:0];
      lo8_q   <= lo7_q;
      hour8_q <= hour7_q;
      hms9_q  <= hms_d;
      // align with the date path
      hms10_q <= hms9_q;
      hms11_q <= hms10_q;
    end
  end

  assign hms_o = hms11_q;

endmodule

/* sv/ucal_date.sv */
module ucal_date (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [ucal_pkg::DAYS_W-1:0] days_i,
  output logic                        valid_o,
  output ucal_pkg::ucal_date_t        date_o
);

  // century boundaries inside the day range (march-based 400-year cycle)
  localparam logic [15:0] C1_DAYS   = 16'd11017;
  localparam logic [15:0] C2_DAYS   = 16'd47541;
  localparam logic [16:0] C0_OFS    = 17'd25508;
  localparam logic [16:0] WD_OFS    = 17'd3;
  localparam logic [16:0] WD_RECIP  = 17'd74898;
  localparam int unsigned WD_SH     = 19;
  localparam logic [2:0]  WD_DIV    = 3'd7;
  localparam logic [10:0] Y4_DIV    = 11'd1461;
  localparam logic [17:0] Y4_RECIP  = 18'd183734;
  localparam int unsigned Y4_SH     = 28;
  localparam logic [7:0]  MON_DIV   = 8'd153;
  localparam logic [11:0] MON_MUL   = 12'd2140;
  localparam logic [9:0]  MON_ADD   = 10'd856;
  localparam int unsigned MON_SH    = 16;
  localparam logic [7:0]  MDAY_RECIP = 8'd205;
  localparam logic [11:0] BASE_YEAR = 12'd1900;
  localparam logic [6:0]  CENTURY   = 7'd100;

  logic [7:0] v_q;

  // stage 4 signals
  logic        ge1_d, ge2_d;
  logic [1:0]  b_d;
  logic [16:0] c_full_d, wy_d;
  logic [33:0] pw_d;
  logic [15:0] c4_q;
  logic [1:0]  b4_q, b5_q, b6_q, b7_q, b8_q, b9_q, b10_q;
  logic [16:0] wy4_q;
  logic [33:0] pw4_q;
  // stage 5 signals
  logic [17:0] x5_d, x5_q;
  logic [35:0] pd_d, pd5_q;
  logic [16:0] wr_full_d;
  logic [3:0]  wr5_q;
  // stage 6 signals
  logic [6:0]  d0_d, d6_q, d7_q, d8_q, d9_q, d10_q;
  logic [17:0] rd_full_d;
  logic [11:0] rd6_q, rd_fix_d;
  logic [3:0]  wd_fix_d;
  logic [2:0]  wd6_q, wd7_q, wd8_q, wd9_q, wd10_q;
  logic        dcarry_d;
  // stage 7 signals
  logic [8:0]  e7_q;
  // stage 8 signals
  logic [10:0] y8_d, y8_q;
  logic [19:0] pe_d, pe8_q;
  // stage 9 signals
  logic [3:0]  m0_d, m9_q, m10_q;
  logic [10:0] rm_full_d;
  logic [8:0]  rm9_q, rm_fix_d;
  logic        mcarry_d;
  logic [7:0]  rm10_q;
  // stage 11 signals
  logic [15:0] pmd_d;
  logic        late_d;
  ucal_pkg::ucal_date_t date_d, date_q;

  // stage 4: century index and day within the century, weekday product
  always_comb begin
    ge1_d = (days_i >= C1_DAYS);
    ge2_d = (days_i >= C2_DAYS);
    b_d   = {1'b0, ge1_d} + {1'b0, ge2_d};
    if (ge2_d) begin
      c_full_d = 17'(days_i) - 17'(C2_DAYS);
    end else if (ge1_d) begin
      c_full_d = 17'(days_i) - 17'(C1_DAYS);
    end else begin
      c_full_d = 17'(days_i) + C0_OFS;
    end
    wy_d = 17'(days_i) + WD_OFS;
    pw_d = 34'(wy_d) * 34'(WD_RECIP);
  end

  // stage 5: four-year quotient product, weekday remainder estimate
  assign x5_d      = {c4_q, 2'b11};
  assign pd_d      = 36'(x5_d) * 36'(Y4_RECIP);
  assign wr_full_d = wy4_q - 17'(pw4_q[33:WD_SH]) * 17'(WD_DIV);

  // stage 6: four-year estimate and remainder, weekday correction
  assign d0_d      = pd5_q[34:Y4_SH];
  assign rd_full_d = x5_q - 18'(d0_d) * 18'(Y4_DIV);
  assign wd_fix_d  = (wr5_q >= 4'(WD_DIV)) ? (wr5_q - 4'(WD_DIV)) : wr5_q;

  // stage 7: four-year correction, day of the march-based year
  assign dcarry_d = (rd6_q >= 12'(Y4_DIV));
  assign rd_fix_d = dcarry_d ? (rd6_q - 12'(Y4_DIV)) : rd6_q;

  // stage 8: month quotient product, (5e+2)*428 folded into one constant
  assign y8_d = {e7_q, 2'b00} + 11'(e7_q) + 11'd2;
  assign pe_d = 20'(e7_q) * 20'(MON_MUL) + 20'(MON_ADD);

  // stage 9: month estimate and remainder
  assign m0_d      = pe8_q[19:MON_SH];
  assign rm_full_d = y8_q - 11'(m0_d) * 11'(MON_DIV);

  // stage 10: month correction
  assign mcarry_d = (rm9_q >= 9'(MON_DIV));
  assign rm_fix_d = mcarry_d ? (rm9_q - 9'(MON_DIV)) : rm9_q;

  // stage 11: day of month, month and year from the march-based fields
  always_comb begin
    pmd_d          = 16'(rm10_q) * 16'(MDAY_RECIP);
    late_d         = (m10_q >= 4'd10);
    date_d.mday    = pmd_d[14:10] + 5'd1;
    date_d.month   = late_d ? (m10_q - 4'd9) : (m10_q + 4'd3);
    date_d.year    = BASE_YEAR + 12'(b10_q) * 12'(CENTURY) + 12'(d10_q) + 12'(late_d);
    date_d.weekday = wd10_q;
  end

  // valid bits, one per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c4_q   <= c_full_d[15:0];
      b4_q   <= b_d;
      wy4_q  <= wy_d;
      pw4_q  <= pw_d;
      x5_q   <= x5_d;
      pd5_q  <= pd_d;
      wr5_q  <= wr_full_d[3:0];
      b5_q   <= b4_q;
      d6_q   <= d0_d;
      rd6_q  <= rd_full_d[11:0];
      wd6_q  <= wd_fix_d[2:0];
      b6_q   <= b5_q;
      d7_q   <= d6_q + 7'(dcarry_d);
      e7_q   <= rd_fix_d[10:2];
      wd7_q  <= wd6_q;
      b7_q   <= b6_q;
      y8_q   <= y8_d;
      pe8_q  <= pe_d;
      d8_q   <= d7_q;
      wd8_q  <= wd7_q;
      b8_q   <= b7_q;
      m9_q   <= m0_d;
      rm9_q  <= rm_full_d[8:0];
      d9_q   <= d8_q;
      wd9_q  <= wd8_q;
      b9_q   <= b8_q;
      m10_q  <= m9_q + 4'(mcarry_d);
      rm10_q <= rm_fix_d[7:0];
      d10_q  <= d9_q;
      wd10_q <= wd9_q;
      b10_q  <= b9_q;
      date_q <= date_d;
    end
  end

  assign valid_o = v_q[7];
  assign date_o  = date_q;

endmodule

/* sv/ucal_skid.sv */
module ucal_skid (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  ucal_pkg::ucal_result_t data_i,
  output logic                   adv_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output ucal_pkg::ucal_result_t data_o
);

  logic                   full_q;
  ucal_pkg::ucal_result_t hold_q;

  // catch a stalled word so the pipeline can still advance in the cycle that the word stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (full_q) begin
      if (ready_i) begin
        full_q <= 1'b0;
      end
    end else if (valid_i && !ready_i) begin
      full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!full_q && valid_i && !ready_i) begin
      hold_q <= data_i;
    end
  end

  // held word is older than the last pipeline stage, so it goes first
  assign adv_o   = !full_q;
  assign valid_o = full_q || valid_i;
  assign data_o  = full_q ? hold_q : data_i;

endmodule

/* sv/unix_seconds_to_calendar_top.sv */
// unix seconds to calendar converter
//
// input channel: in_valid_i / in_ready_o carry seconds_count_i, an unsigned
// count of seconds since 1970-01-01 00:00:00. output channel: out_valid_o /
// out_ready_i carry year, month, day of month, hour, minute, second and
// weekday (0 Monday .. 6 Sunday). every input word gives exactly one result.
// the pipeline has 11 register stages, and when the output is not stalled
// a result goes straight from the last stage to the output.
// throughput: one word per cycle, sustained while out_ready_i stays high.
// stall: an output register stage plus a one-word holding register sit at
// the end; when a result is not taken it moves into the holding register
// while the pipeline still advances in that cycle, after that in_ready_o drops
// and the whole pipeline freezes until the held word is taken.
// in_ready_o comes from a register, with no path from out_ready_i.
// reset: all valid bits clear at once, no result is pending after reset.
module unix_seconds_to_calendar_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ucal_pkg::SECS_W-1:0]  seconds_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ucal_pkg::YEAR_W-1:0]  year_o,
  output logic [ucal_pkg::MONTH_W-1:0] month_o,
  output logic [ucal_pkg::MDAY_W-1:0]  day_of_month_o,
  output logic [ucal_pkg::HOUR_W-1:0]  hour_o,
  output logic [ucal_pkg::MIN_W-1:0]   minute_o,
  output logic [ucal_pkg::SEC_W-1:0]   second_o,
  output logic [ucal_pkg::WDAY_W-1:0]  weekday_o
);

  logic                   adv;
  logic                   day_valid;
  logic                   res_valid;
  ucal_pkg::ucal_day_t    day;
  ucal_pkg::ucal_date_t   date;
  ucal_pkg::ucal_hms_t    hms;
  ucal_pkg::ucal_result_t res;
  ucal_pkg::ucal_result_t out_res;

  // days and time of day
  ucal_day_split u_day_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .secs_i  (seconds_count_i),
    .valid_o (day_valid),
    .day_o   (day)
  );

  // calendar date and weekday
  ucal_date u_date (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (day_valid),
    .days_i  (day.days),
    .valid_o (res_valid),
    .date_o  (date)
  );

  // hour, minute, second
  ucal_clock u_clock (
    .clk_i (clk_i),
    .en_i  (adv),
    .tod_i (day.tod),
    .hms_o (hms)
  );

  assign res.date = date;
  assign res.hms  = hms;

  // output holding stage
  ucal_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .data_i  (res),
    .adv_o   (adv),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res)
  );

  assign in_ready_o     = adv;
  assign year_o         = out_res.date.year;
  assign month_o        = out_res.date.month;
  assign day_of_month_o = out_res.date.mday;
  assign weekday_o      = out_res.date.weekday;
  assign hour_o         = out_res.hms.hour;
  assign minute_o       = out_res.hms.minute;
  assign second_o       = out_res.hms.second;

  // input only blocked while a finished word waits at the output
  a_block_needs_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o
  ) else $error("input blocked with no result pending");

  // date fields in range on every result
  a_date_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_o >= 4'd1 && month_o <= 4'd12 &&
                     day_of_month_o >= 5'd1 && weekday_o <= 3'd6)
  ) else $error("date field out of range");

  // clock fields in range on every result
  a_time_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_o <= 5'd23 && minute_o <= 6'd59 && second_o <= 6'd59)
  ) else $error("time field out of range");

endmodule
